FILE: design/smac_pkg.sv
// Shared types, codes and constants for the sized memory access block.
package smac_pkg;

  localparam int unsigned WORD_COUNT_DEFAULT = 4096;
  localparam logic [15:0] MEMORY_BYTES_RESET = 16'h8000;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_STORE = 2'd1;
  localparam logic [1:0] CMD_CAS   = 2'd2;

  localparam logic [1:0] SIZE_FOUR = 2'd2;

  localparam logic [2:0] FAULT_NONE       = 3'd0;
  localparam logic [2:0] FAULT_LOAD_BND   = 3'd1;
  localparam logic [2:0] FAULT_LOAD_ALIGN = 3'd2;
  localparam logic [2:0] FAULT_STORE_BND  = 3'd3;
  localparam logic [2:0] FAULT_STORE_ALIGN = 3'd4;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_STORE,
    OP_CAS
  } op_e;

  typedef enum logic {
    ST_FETCH,
    ST_EXEC
  } back_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  size_code;
    logic [31:0] address;
    logic [63:0] write_value;
    logic [31:0] compare_value;
  } req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        success;
    logic [2:0]  fault_code;
    logic [31:0] fault_address;
  } resp_t;

  typedef struct packed {
    op_e         op;
    logic [1:0]  size_code;
    logic [31:0] address;
    logic [63:0] write_value;
    logic [31:0] compare_value;
    logic [2:0]  fault_code;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

FILE: design/smac_front.sv
// Front end: size register, request checks and classification into queue entries.
module smac_front #(
  parameter int unsigned WORD_COUNT = smac_pkg::WORD_COUNT_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  smac_pkg::req_t          in_word_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [15:0]             cfg_data_i,
  input  smac_pkg::queue_status_t q_status_i,
  output logic                    q_push_o,
  output smac_pkg::entry_t        q_entry_o
);

  localparam logic [32:0] StorageBytes = 33'(WORD_COUNT * 8);

  logic [15:0] memory_bytes_q;
  logic [15:0] memory_bytes_d;
  logic [32:0] limit;
  logic [32:0] end_addr;
  logic [1:0]  size_eff;
  logic [3:0]  size_bytes;
  logic [2:0]  align_mask;
  logic        is_store;
  logic        bounds_fault;
  logic        align_fault;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    memory_bytes_d = memory_bytes_q;
    if (cfg_valid_i) begin
      memory_bytes_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_bytes_q <= smac_pkg::MEMORY_BYTES_RESET;
    end else begin
      memory_bytes_q <= memory_bytes_d;
    end
  end

  always_comb begin
    size_eff     = (in_word_i.cmd == smac_pkg::CMD_CAS) ? smac_pkg::SIZE_FOUR
                                                        : in_word_i.size_code;
    size_bytes   = 4'b0001 << size_eff;
    align_mask   = 3'(size_bytes - 4'd1);
    is_store     = (in_word_i.cmd == smac_pkg::CMD_STORE);
    limit        = ({17'b0, memory_bytes_q} > StorageBytes) ? StorageBytes
                                                            : {17'b0, memory_bytes_q};
    end_addr     = {1'b0, in_word_i.address} + {29'b0, size_bytes};
    bounds_fault = (end_addr > limit);
    align_fault  = |(in_word_i.address[2:0] & align_mask);

    q_entry_o.size_code     = size_eff;
    q_entry_o.address       = in_word_i.address;
    q_entry_o.write_value   = in_word_i.write_value;
    q_entry_o.compare_value = in_word_i.compare_value;
    q_entry_o.fault_code    = smac_pkg::FAULT_NONE;
    q_entry_o.op            = smac_pkg::OP_NONE;

    case (in_word_i.cmd)
      smac_pkg::CMD_LOAD, smac_pkg::CMD_STORE, smac_pkg::CMD_CAS: begin
        if (bounds_fault) begin
          q_entry_o.fault_code = is_store ? smac_pkg::FAULT_STORE_BND
                                          : smac_pkg::FAULT_LOAD_BND;
        end else if (align_fault) begin
          q_entry_o.fault_code = is_store ? smac_pkg::FAULT_STORE_ALIGN
                                          : smac_pkg::FAULT_LOAD_ALIGN;
        end else if (in_word_i.cmd == smac_pkg::CMD_LOAD) begin
          q_entry_o.op = smac_pkg::OP_LOAD;
        end else if (is_store) begin
          q_entry_o.op = smac_pkg::OP_STORE;
        end else begin
          q_entry_o.op = smac_pkg::OP_CAS;
        end
      end
      default: begin
        q_entry_o.op = smac_pkg::OP_NONE;
      end
    endcase
  end

  assign in_stall_o = q_status_i.full;
  assign q_push_o   = in_valid_i && !q_status_i.full;

endmodule

FILE: design/smac_queue.sv
// Short queue of classified requests between the front and back ends.
module smac_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  smac_pkg::entry_t        push_entry_i,
  input  logic                    pop_i,
  output smac_pkg::entry_t        head_o,
  output smac_pkg::queue_status_t status_o
);

  smac_pkg::entry_t                   slots_q [smac_pkg::QUEUE_DEPTH];
  logic [smac_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
  logic [smac_pkg::QUEUE_PTR_W-1:0]   wr_ptr_d;
  logic [smac_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
  logic [smac_pkg::QUEUE_PTR_W-1:0]   rd_ptr_d;
  logic [smac_pkg::QUEUE_CNT_W-1:0]   count_q;
  logic [smac_pkg::QUEUE_CNT_W-1:0]   count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign head_o         = slots_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == smac_pkg::QUEUE_CNT_W'(smac_pkg::QUEUE_DEPTH));

endmodule

FILE: design/smac_back.sv
// Back end: word memory, read-modify-write of lanes and the result register.
module smac_back #(
  parameter int unsigned WORD_COUNT = smac_pkg::WORD_COUNT_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  smac_pkg::queue_status_t q_status_i,
  input  smac_pkg::entry_t        q_head_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output smac_pkg::resp_t         out_word_o
);

  localparam int unsigned AddrW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  function automatic logic [63:0] lane_mask(input logic [1:0] size_code);
    logic [63:0] mask;
    case (size_code)
      2'd0:    mask = 64'h0000_0000_0000_00FF;
      2'd1:    mask = 64'h0000_0000_0000_FFFF;
      2'd2:    mask = 64'h0000_0000_FFFF_FFFF;
      default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return mask;
  endfunction

  smac_pkg::back_state_e state_q;
  smac_pkg::back_state_e state_d;
  smac_pkg::entry_t      cur_q;
  smac_pkg::resp_t       out_q;
  smac_pkg::resp_t       out_d;
  logic                  out_valid_q;
  logic                  out_valid_d;
  logic [63:0]           mem_q [WORD_COUNT];
  logic [63:0]           rdata_q;
  logic                  rd_en;
  logic                  wr_en;
  logic                  load_out;
  logic [AddrW-1:0]      rd_idx;
  logic [AddrW-1:0]      wr_idx;
  logic [5:0]            shift;
  logic [63:0]           mask;
  logic [63:0]           lane;
  logic [63:0]           merged;
  logic [63:0]           new_lane;
  logic                  cas_match;
  logic                  needs_write;

  assign rd_idx = q_head_i.address[3 +: AddrW];
  assign wr_idx = cur_q.address[3 +: AddrW];

  always_comb begin
    shift     = {cur_q.address[2:0], 3'b000};
    mask      = lane_mask(cur_q.size_code);
    lane      = (rdata_q >> shift) & mask;
    cas_match = (lane == {32'b0, cur_q.compare_value});
    new_lane  = cur_q.write_value & mask;
    merged    = (rdata_q & ~(mask << shift)) | (new_lane << shift);

    out_d.read_data     = '0;
    out_d.success       = 1'b0;
    out_d.fault_code    = cur_q.fault_code;
    out_d.fault_address = (cur_q.fault_code != smac_pkg::FAULT_NONE) ? cur_q.address : '0;
    needs_write         = 1'b0;

    case (cur_q.op)
      smac_pkg::OP_LOAD: begin
        out_d.read_data = lane;
        out_d.success   = 1'b1;
      end
      smac_pkg::OP_STORE: begin
        out_d.success = 1'b1;
        needs_write   = 1'b1;
      end
      smac_pkg::OP_CAS: begin
        out_d.read_data = lane;
        if (cas_match) begin
          out_d.success = 1'b1;
          needs_write   = 1'b1;
        end
      end
      default: begin
        out_d.read_data = '0;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      smac_pkg::ST_FETCH: begin
        if (!q_status_i.empty) begin
          q_pop_o = 1'b1;
          rd_en   = 1'b1;
          state_d = smac_pkg::ST_EXEC;
        end
      end
      smac_pkg::ST_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          wr_en    = needs_write;
          state_d  = smac_pkg::ST_FETCH;
        end
      end
      default: begin
        state_d = smac_pkg::ST_FETCH;
      end
    endcase
    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smac_pkg::ST_FETCH;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx];
    end
    if (wr_en) begin
      mem_q[wr_idx] <= merged;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_write_in_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == smac_pkg::ST_EXEC))
    else $error("Memory written outside the execute step.");

  a_read_then_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (state_q == smac_pkg::ST_EXEC))
    else $error("Memory read not followed by the execute step.");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load_out)
    else $error("Held result overwritten while the receiver stalls.");

  a_fault_no_success : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.fault_code != smac_pkg::FAULT_NONE)) |-> !out_q.success)
    else $error("Faulted request reported as successful.");

endmodule

FILE: design/sized_memory_access_with_cas.sv
// Top level of the byte-addressed memory with sized loads, stores and compare-and-swap.
//
// Requests arrive on the in channel (in_valid_i, in_stall_o, in_word_i) and one
// result word per request leaves on the out channel (out_valid_o, out_stall_i,
// out_word_o). A word moves when valid is high and stall is low at a rising edge.
// The memory size register is written over cfg_valid_i/cfg_ready_o/cfg_data_i;
// ready is always high and the new size applies to requests accepted afterwards.
// The front end checks bounds and alignment as a request is accepted and places it
// in a two-entry queue. The back end takes one queued request at a time: a fetch
// step reads the memory word, and an execute step merges the lane, writes it back
// and loads the result register, waiting while the receiver stalls a held result.
// It takes no new request before the execute step is done, as the read and the write
// share the single memory port. When the receiver stalls, the result is held, the back
// end waits, the queue fills and then in_stall_o rises. Reset empties the queue
// and result register and sets the memory size to 32768 bytes; memory contents
// are not cleared.
module sized_memory_access_with_cas #(
  parameter int unsigned WORD_COUNT = smac_pkg::WORD_COUNT_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  smac_pkg::req_t  in_word_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output smac_pkg::resp_t out_word_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [15:0]     cfg_data_i
);

  smac_pkg::queue_status_t q_status;
  smac_pkg::entry_t        push_entry;
  smac_pkg::entry_t        head_entry;
  logic                    q_push;
  logic                    q_pop;

  smac_front #(
    .WORD_COUNT(WORD_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  smac_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(push_entry),
    .pop_i       (q_pop),
    .head_o      (head_entry),
    .status_o    (q_status)
  );

  smac_back #(
    .WORD_COUNT(WORD_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_head_i   (head_entry),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

FILE: tb/sv/sized_memory_access_with_cas_tb.sv
// Self-checking testbench for the sized memory access block with compare-and-swap.
module sized_memory_access_with_cas_tb;
  import smac_pkg::*;

  localparam logic [1:0]  CMD_RESERVED = 2'd3;
  localparam logic [1:0]  SIZE_ONE = 2'd0;
  localparam logic [1:0]  SIZE_TWO = 2'd1;
  localparam logic [1:0]  SIZE_EIGHT = 2'd3;
  localparam int unsigned WORDS = WORD_COUNT_DEFAULT;
  localparam int unsigned STORAGE_BYTES = WORD_COUNT_DEFAULT * 8;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AT_WORD = 150;
  localparam int unsigned PHASES = 8;
  localparam int unsigned RANDOM_SIZE_PHASE = 6;
  localparam int unsigned PAUSE_PHASE = 2;
  localparam int unsigned DIRECTED_COUNT = 25;
  localparam logic        FIXED = 1'b1;
  localparam logic        PREDICTED = 1'b0;
  localparam resp_t       NO_RESP = '0;
  localparam logic [63:0] ONES64 = '1;

  localparam logic [15:0] SIZE_SETTINGS [PHASES] = '{
    16'd32768, 16'd0, 16'd65535, 16'd8, 16'd1, 16'd20000, 16'd0, 16'd24573
  };
  localparam int unsigned PHASE_WORDS [PHASES] = '{375, 50, 300, 60, 50, 300, 200, 240};

  typedef struct packed {
    req_t  rq;
    logic  fixed;
    resp_t rs;
  } stim_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_stall_o;
  req_t    in_word_i;
  logic    out_valid_o;
  logic    out_stall_i;
  resp_t   out_word_o;
  logic    cfg_valid_i;
  logic    cfg_ready_o;
  logic [15:0] cfg_data_i;

  bit [63:0]   mem_image [WORDS];
  bit [7:0]    byte_written [WORDS];
  int unsigned bound_bytes = MEMORY_BYTES_RESET;
  resp_t       pending_responses [$];
  int unsigned mismatch_count = 0;
  int unsigned accepted_words = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_burst = 0;
  int unsigned rx_burst = 0;
  bit          long_hold_request = 1'b0;

  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    {CMD_STORE, SIZE_EIGHT, 32'h0000_0000, ONES64, 32'h0,
     FIXED, 64'h0, 1'b1, FAULT_NONE, 32'h0},
    {CMD_STORE, SIZE_EIGHT, 32'h0000_7FF8, 64'h0123_4567_89AB_CDEF, 32'h0,
     FIXED, 64'h0, 1'b1, FAULT_NONE, 32'h0},
    {CMD_LOAD, SIZE_EIGHT, 32'h0000_0000, 64'h0, 32'h0,
     FIXED, ONES64, 1'b1, FAULT_NONE, 32'h0},
    {CMD_LOAD, SIZE_EIGHT, 32'h0000_7FF8, 64'h0, 32'h0,
     FIXED, 64'h0123_4567_89AB_CDEF, 1'b1, FAULT_NONE, 32'h0},
    {CMD_LOAD, SIZE_ONE, 32'h0000_7FFF, 64'h0, 32'h0,
     FIXED, 64'h01, 1'b1, FAULT_NONE, 32'h0},
    {CMD_LOAD, SIZE_EIGHT, 32'h0000_7FF9, 64'h0, 32'h0,
     FIXED, 64'h0, 1'b0, FAULT_LOAD_BND, 32'h0000_7FF9},
    {CMD_LOAD, SIZE_TWO, 32'h0000_0001, 64'h0, 32'h0,
     FIXED, 64'h0, 1'b0, FAULT_LOAD_ALIGN, 32'h0000_0001},
    {CMD_STORE, SIZE_FOUR, 32'h0000_8000, ONES64, 32'h0,
     FIXED, 64'h0, 1'b0, FAULT_STORE_BND, 32'h0000_8000},
    {CMD_STORE, SIZE_FOUR, 32'h0000_0002, ONES64, 32'h0,
     FIXED, 64'h0, 1'b0, FAULT_STORE_ALIGN, 32'h0000_0002},
    {CMD_LOAD, SIZE_EIGHT, 32'hFFFF_FFFF, 64'h0, 32'h0,
     FIXED, 64'h0, 1'b0, FAULT_LOAD_BND, 32'hFFFF_FFFF},
    {CMD_STORE, SIZE_ONE, 32'hFFFF_FFF8, ONES64, 32'h0,
     FIXED, 64'h0, 1'b0, FAULT_STORE_BND, 32'hFFFF_FFF8},
    {CMD_STORE, SIZE_ONE, 32'h0000_0003, 64'hFFFF_FFFF_FFFF_FF00, 32'h0,
     PREDICTED, NO_RESP},
    {CMD_STORE, SIZE_TWO, 32'h0000_0006, 64'hDEAD_BEEF_CAFE_1234, 32'h0,
     PREDICTED, NO_RESP},
    {CMD_LOAD, SIZE_EIGHT, 32'h0000_0000, 64'h0, 32'h0, PREDICTED, NO_RESP},
    {CMD_LOAD, SIZE_ONE, 32'h0000_0001, 64'h0, 32'h0, PREDICTED, NO_RESP},
    {CMD_CAS, SIZE_EIGHT, 32'h0000_7FFC, 64'hFFFF_FFFF_7654_3210, 32'h0123_4567,
     FIXED, 64'h0123_4567, 1'b1, FAULT_NONE, 32'h0},
    {CMD_CAS, SIZE_ONE, 32'h0000_7FFC, 64'h0, 32'h0123_4567,
     FIXED, 64'h7654_3210, 1'b0, FAULT_NONE, 32'h0},
    {CMD_CAS, SIZE_FOUR, 32'h0000_0002, 64'h0, 32'h0,
     FIXED, 64'h0, 1'b0, FAULT_LOAD_ALIGN, 32'h0000_0002},
    {CMD_CAS, SIZE_FOUR, 32'h0000_7FFE, 64'h0, 32'h0,
     FIXED, 64'h0, 1'b0, FAULT_LOAD_BND, 32'h0000_7FFE},
    {CMD_RESERVED, SIZE_EIGHT, 32'h0000_0000, ONES64, 32'hFFFF_FFFF, FIXED, NO_RESP},
    {CMD_LOAD, SIZE_FOUR, 32'h0000_7FFC, 64'h0, 32'h0, PREDICTED, NO_RESP},
    {CMD_STORE, SIZE_EIGHT, 32'h0000_0008, 64'h0, 32'h0,
     FIXED, 64'h0, 1'b1, FAULT_NONE, 32'h0},
    {CMD_LOAD, SIZE_EIGHT, 32'h0000_0008, 64'h0, 32'h0,
     FIXED, 64'h0, 1'b1, FAULT_NONE, 32'h0},
    {CMD_LOAD, SIZE_TWO, 32'h0000_7FFE, 64'h0, 32'h0, PREDICTED, NO_RESP},
    {CMD_CAS, SIZE_TWO, 32'h0000_0004, 64'h0, 32'h1234_FFFF, PREDICTED, NO_RESP}
  };

  sized_memory_access_with_cas dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [7:0] lane_bytes(int unsigned nbytes, logic [31:0] address);
    return (8'hFF >> (8 - nbytes)) << address[2:0];
  endfunction

  function automatic int unsigned access_bytes(req_t rq);
    return (rq.cmd == CMD_CAS) ? 4 : (1 << rq.size_code);
  endfunction

  // Works out the response to one request and applies its effect on the memory image.
  function automatic resp_t predict_access(req_t rq);
    resp_t       rs;
    int unsigned nbytes;
    int unsigned widx;
    logic [5:0]  shift;
    logic [63:0] lmask;
    logic [63:0] word;
    logic [63:0] lane;
    logic        is_store;
    rs = '0;
    if (rq.cmd == CMD_RESERVED) return rs;
    is_store = (rq.cmd == CMD_STORE);
    nbytes = access_bytes(rq);
    if ({1'b0, rq.address} + 33'(nbytes) > 33'(bound_bytes)) begin
      rs.fault_code = is_store ? FAULT_STORE_BND : FAULT_LOAD_BND;
      rs.fault_address = rq.address;
      return rs;
    end
    if ((rq.address & 32'(nbytes - 1)) != 32'd0) begin
      rs.fault_code = is_store ? FAULT_STORE_ALIGN : FAULT_LOAD_ALIGN;
      rs.fault_address = rq.address;
      return rs;
    end
    widx = rq.address >> 3;
    shift = {rq.address[2:0], 3'b000};
    lmask = (nbytes == 8) ? ONES64 : (64'd1 << (nbytes * 8)) - 64'd1;
    word = mem_image[widx];
    lane = (word >> shift) & lmask;
    case (rq.cmd)
      CMD_LOAD: begin
        rs.read_data = lane;
        rs.success = 1'b1;
      end
      CMD_STORE: begin
        mem_image[widx] = (word & ~(lmask << shift)) | ((rq.write_value & lmask) << shift);
        byte_written[widx] |= lane_bytes(nbytes, rq.address);
        rs.success = 1'b1;
      end
      default: begin
        if (lane == {32'h0, rq.compare_value}) begin
          mem_image[widx] = (word & ~(lmask << shift)) | ({32'h0, rq.write_value[31:0]} << shift);
          rs.read_data = {32'h0, rq.compare_value};
          rs.success = 1'b1;
        end else begin
          rs.read_data = lane;
        end
      end
    endcase
    return rs;
  endfunction

  // Most addresses are aligned and in bounds near either end of memory, where words get reused.
  function automatic logic [31:0] pick_address(int unsigned nbytes);
    int unsigned r;
    int unsigned slots;
    int unsigned span;
    int unsigned slot;
    r = $urandom_range(99);
    if (r < 70 && bound_bytes >= nbytes) begin
      slots = bound_bytes / nbytes;
      span = (slots < 128 / nbytes) ? slots : 128 / nbytes;
      r = $urandom_range(9);
      if (r < 4) slot = $urandom_range(span - 1);
      else if (r < 8) slot = slots - 1 - $urandom_range(span - 1);
      else slot = $urandom_range(slots - 1);
      return 32'(slot * nbytes);
    end
    if (r < 82) begin
      return (bound_bytes >= 16) ? 32'(bound_bytes - 16 + $urandom_range(31))
                                 : 32'($urandom_range(31));
    end
    if (r < 92) begin
      if (bound_bytes > 256 && $urandom_range(1) == 1)
        return 32'(bound_bytes - 256 + $urandom_range(255));
      return 32'($urandom_range(255));
    end
    return $urandom;
  endfunction

  function automatic req_t random_request();
    req_t        rq;
    int unsigned r;
    int unsigned nbytes;
    int unsigned widx;
    logic [63:0] word;
    r = $urandom_range(99);
    rq.cmd = (r < 35) ? CMD_LOAD : (r < 65) ? CMD_STORE : (r < 95) ? CMD_CAS : CMD_RESERVED;
    rq.size_code = 2'($urandom_range(3));
    rq.write_value = {$urandom, $urandom};
    rq.compare_value = $urandom;
    nbytes = access_bytes(rq);
    rq.address = pick_address(nbytes);
    if ((rq.cmd == CMD_LOAD || rq.cmd == CMD_CAS) &&
        {1'b0, rq.address} + 33'(nbytes) <= 33'(bound_bytes) &&
        (rq.address & 32'(nbytes - 1)) == 32'd0) begin
      widx = rq.address >> 3;
      if ((byte_written[widx] & lane_bytes(nbytes, rq.address)) !=
          lane_bytes(nbytes, rq.address)) begin
        // The lane holds bytes never stored, so the read becomes a store of the same lane.
        if (rq.cmd == CMD_CAS) rq.size_code = SIZE_FOUR;
        rq.cmd = CMD_STORE;
      end else if (rq.cmd == CMD_CAS && $urandom_range(1) == 1) begin
        word = mem_image[widx];
        rq.compare_value = 32'(word >> {rq.address[2:0], 3'b000});
      end
    end
    return rq;
  endfunction

  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(39) == 0) begin
      burst = $urandom_range(40, 20);
      return 0;
    end
    return $urandom_range(13);
  endfunction

  task automatic report_mismatch(string label, resp_t want, resp_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected data %h ok %b fault %0d addr %h, got data %h ok %b fault %0d addr %h",
               label, want.read_data, want.success, want.fault_code, want.fault_address,
               got.read_data, got.success, got.fault_code, got.fault_address);
  endtask

  // Entered and left at a falling edge; the word is accepted at the first rising edge at which in_stall_o is low.
  task automatic send_request(req_t rq, logic fixed, resp_t fixed_rs);
    int unsigned gap;
    resp_t       rs;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= rq;
    do @(posedge clk_i); while (in_stall_o);
    rs = predict_access(rq);
    pending_responses.push_back(fixed ? fixed_rs : rs);
    accepted_words++;
    if (accepted_words == HOLD_AT_WORD) long_hold_request = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic drain_responses();
    in_valid_i <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_memory_bytes(logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    bound_bytes = (value > STORAGE_BYTES) ? STORAGE_BYTES : value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_responses
    resp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected response", NO_RESP, out_word_o);
      end else begin
        want = pending_responses.pop_front();
        if (want.read_data !== out_word_o.read_data || want.success !== out_word_o.success ||
            want.fault_code !== out_word_o.fault_code ||
            want.fault_address !== out_word_o.fault_address)
          report_mismatch("response mismatch", want, out_word_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : response_sink
    int unsigned stall_len;
    out_stall_i = 1'b1;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        stall_len = LONG_HOLD_CYCLES;
      end else begin
        stall_len = draw_gap(rx_burst);
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned k;
    logic [15:0] setting;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_rows[i])
      send_request(directed_rows[i].rq, directed_rows[i].fixed, directed_rows[i].rs);
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain_responses();
        setting = (phase == RANDOM_SIZE_PHASE) ? 16'($urandom_range(65535))
                                               : SIZE_SETTINGS[phase];
        write_memory_bytes(setting);
      end
      for (k = 0; k < PHASE_WORDS[phase]; k++) begin
        if (phase == PAUSE_PHASE && k == PHASE_WORDS[phase] / 2) drain_responses();
        send_request(random_request(), PREDICTED, NO_RESP);
      end
    end
    drain_responses();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
